@@ rtl/vau_pkg.sv @@
package vau_pkg;

	// Word and field widths fixed by the interface.
	localparam int WORD_W = 32;
	localparam int CMD_W = 4;
	localparam int LANES = 3;
	localparam int PROD_W = 2 * WORD_W;

	// Square root unit: a 64-bit radicand gives a 32-bit root, one bit per stage.
	localparam int SQ_IN_W = PROD_W;
	localparam int ROOT_W = WORD_W;
	localparam int SQ_REM_W = ROOT_W + 2;

	// Depth of the queue between the front and the back.
	localparam int QUEUE_DEPTH = 4;

	// Command codes as they arrive on the command port.
	localparam logic [CMD_W-1:0] CMD_ADD = 4'd0;
	localparam logic [CMD_W-1:0] CMD_SUB = 4'd1;
	localparam logic [CMD_W-1:0] CMD_DOT = 4'd2;
	localparam logic [CMD_W-1:0] CMD_SCALE = 4'd3;
	localparam logic [CMD_W-1:0] CMD_NORMSQ = 4'd4;
	localparam logic [CMD_W-1:0] CMD_NORM = 4'd5;
	localparam logic [CMD_W-1:0] CMD_NORMALIZE = 4'd6;
	localparam logic [CMD_W-1:0] CMD_COSINE = 4'd7;
	localparam logic [CMD_W-1:0] CMD_RIGHT = 4'd8;

	// Operation class decided by the front.
	typedef enum logic [3:0] {
		OP_NONE,
		OP_ADD,
		OP_SUB,
		OP_DOT,
		OP_SCALE,
		OP_NORMSQ,
		OP_NORM,
		OP_NORMALIZE,
		OP_COSINE,
		OP_RIGHT
	} op_t;

	typedef logic [LANES-1:0][WORD_W-1:0] vec_t;

	// Word as it arrives at the input port.
	typedef struct packed {
		logic [CMD_W-1:0] cmd;
		vec_t a;
		vec_t b;
		logic [WORD_W-1:0] sf;
	} raw_t;

	// Word after classification, as it sits in the queue.
	typedef struct packed {
		op_t op;
		vec_t a;
		vec_t b;
		logic [WORD_W-1:0] sf;
	} item_t;

	// Result word handed to the output port.
	typedef struct packed {
		vec_t r;
		logic [WORD_W-1:0] sc;
		logic right;
		logic sat;
		logic divz;
	} res_t;

endpackage

@@ rtl/vau_front.sv @@
module vau_front (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input vau_pkg::raw_t in_word,
	input logic pop,
	output logic head_valid,
	output vau_pkg::item_t head_item
);
	import vau_pkg::*;

	localparam int PTR_W = $clog2(QUEUE_DEPTH);

	item_t q_mem_q [QUEUE_DEPTH];
	logic [PTR_W-1:0] wptr_q;
	logic [PTR_W-1:0] rptr_q;
	logic [PTR_W:0] count_q;
	item_t item;
	logic push;
	logic take;

	// Classify the command into an operation.
	always_comb begin
		item.a = in_word.a;
		item.b = in_word.b;
		item.sf = in_word.sf;
		case (in_word.cmd)
			CMD_ADD: item.op = OP_ADD;
			CMD_SUB: item.op = OP_SUB;
			CMD_DOT: item.op = OP_DOT;
			CMD_SCALE: item.op = OP_SCALE;
			CMD_NORMSQ: item.op = OP_NORMSQ;
			CMD_NORM: item.op = OP_NORM;
			CMD_NORMALIZE: item.op = OP_NORMALIZE;
			CMD_COSINE: item.op = OP_COSINE;
			CMD_RIGHT: item.op = OP_RIGHT;
			default: item.op = OP_NONE;
		endcase
	end

	// Queue handshake.
	assign in_ready = count_q != (PTR_W+1)'(QUEUE_DEPTH);
	assign push = in_valid && in_ready;
	assign head_valid = count_q != '0;
	assign take = pop && head_valid;
	assign head_item = q_mem_q[rptr_q];

	// Queue storage.
	always_ff @(posedge clk) begin
		if (push) begin
			q_mem_q[wptr_q] <= item;
		end
	end

	// Queue pointers and fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wptr_q <= '0;
			rptr_q <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wptr_q <= wptr_q + 1'b1;
			end
			if (take) begin
				rptr_q <= rptr_q + 1'b1;
			end
			case ({push, take})
				2'b10: count_q <= count_q + 1'b1;
				2'b01: count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

endmodule

@@ rtl/vau_sqrt.sv @@
module vau_sqrt (
	input logic clk,
	input logic en,
	input logic [vau_pkg::SQ_IN_W-1:0] x,
	output logic [vau_pkg::ROOT_W-1:0] root
);
	import vau_pkg::*;

	localparam int SHIFT_W = SQ_REM_W + 2;
	localparam int TRIAL_W = ROOT_W + 2;

	logic [SQ_REM_W-1:0] rem_s [ROOT_W];
	logic [ROOT_W-1:0] root_s [ROOT_W];
	logic [SQ_IN_W-1:0] x_s [ROOT_W];

	// One root bit per stage: bring down two radicand bits, try the next bit.
	for (genvar k = 0; k < ROOT_W; k++) begin : g_step
		logic [SQ_REM_W-1:0] rem_in;
		logic [ROOT_W-1:0] root_in;
		logic [SQ_IN_W-1:0] x_in;
		logic [SHIFT_W-1:0] shifted;
		logic [TRIAL_W-1:0] trial;
		logic [SHIFT_W:0] diff;

		if (k == 0) begin : g_first
			assign rem_in = '0;
			assign root_in = '0;
			assign x_in = x;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign root_in = root_s[k-1];
			assign x_in = x_s[k-1];
		end

		assign shifted = {rem_in, x_in[SQ_IN_W-1 -: 2]};
		assign trial = {root_in, 2'b01};
		assign diff = {1'b0, shifted} - {{(SHIFT_W+1-TRIAL_W){1'b0}}, trial};

		always_ff @(posedge clk) begin
			if (en) begin
				if (!diff[SHIFT_W]) begin
					rem_s[k] <= diff[SQ_REM_W-1:0];
					root_s[k] <= {root_in[ROOT_W-2:0], 1'b1};
				end else begin
					rem_s[k] <= shifted[SQ_REM_W-1:0];
					root_s[k] <= {root_in[ROOT_W-2:0], 1'b0};
				end
				x_s[k] <= {x_in[SQ_IN_W-3:0], 2'b00};
			end
		end
	end

	assign root = root_s[ROOT_W-1];

endmodule

@@ rtl/vau_div.sv @@
module vau_div #(
	parameter int W = 32,
	parameter int STEPS = 18
) (
	input logic clk,
	input logic en,
	input logic [W-1:0] rem0,
	input logic [1:0] low,
	input logic [W-1:0] den,
	output logic [STEPS-1:0] quo
);

	logic [W-1:0] rem_s [STEPS];
	logic [W-1:0] den_s [STEPS];
	logic [1:0] low_s [STEPS];
	logic [STEPS-1:0] quo_s [STEPS];

	// Restoring division, one quotient bit per stage. The two low dividend bits
	// enter in the first two stages and zeros after them.
	for (genvar t = 0; t < STEPS; t++) begin : g_step
		logic [W-1:0] rem_in;
		logic [W-1:0] den_in;
		logic [1:0] low_in;
		logic [STEPS-1:0] quo_in;
		logic [W:0] shifted;
		logic [W+1:0] diff;

		if (t == 0) begin : g_first
			assign rem_in = rem0;
			assign den_in = den;
			assign low_in = low;
			assign quo_in = '0;
		end else begin : g_next
			assign rem_in = rem_s[t-1];
			assign den_in = den_s[t-1];
			assign low_in = low_s[t-1];
			assign quo_in = quo_s[t-1];
		end

		assign shifted = {rem_in, low_in[1]};
		assign diff = {1'b0, shifted} - {2'b00, den_in};

		always_ff @(posedge clk) begin
			if (en) begin
				if (!diff[W+1]) begin
					rem_s[t] <= diff[W-1:0];
				end else begin
					rem_s[t] <= shifted[W-1:0];
				end
				quo_s[t] <= {quo_in[STEPS-2:0], !diff[W+1]};
				low_s[t] <= {low_in[0], 1'b0};
				den_s[t] <= den_in;
			end
		end
	end

	assign quo = quo_s[STEPS-1];

endmodule

@@ rtl/vau_back.sv @@
module vau_back #(
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic head_valid,
	input vau_pkg::item_t head_item,
	output logic pop,
	output logic res_valid,
	input logic res_ready,
	output vau_pkg::res_t res
);
	import vau_pkg::*;

	localparam int STEPS = FRAC_BITS + 2;
	localparam int SQ_DLY = ROOT_W - 1;
	localparam logic [PROD_W-1:0] FRAC_MASK = (PROD_W'(1) << FRAC_BITS) - PROD_W'(1);
	localparam logic [PROD_W-1:0] POS_MAX = PROD_W'(32'h7FFF_FFFF);
	localparam logic [PROD_W-1:0] NEG_MAX = PROD_W'(32'h8000_0000);

	typedef logic [LANES-1:0][PROD_W-1:0] pvec_t;

	typedef struct packed {
		op_t op;
		vec_t r;
		logic [WORD_W-1:0] sc;
		logic sat;
		logic divz;
		logic [PROD_W-1:0] m;
		logic mneg;
		vec_t ma;
		logic [LANES-1:0] an;
	} side_t;

	// Sign and magnitude to a clipped word; the top bit reports clipping.
	function automatic logic [WORD_W:0] pack(input logic neg, input logic [PROD_W-1:0] mag);
		logic [WORD_W:0] o;
		if (!neg) begin
			if (mag > POS_MAX) begin
				o = {1'b1, POS_MAX[WORD_W-1:0]};
			end else begin
				o = {1'b0, mag[WORD_W-1:0]};
			end
		end else begin
			if (mag > NEG_MAX) begin
				o = {1'b1, NEG_MAX[WORD_W-1:0]};
			end else begin
				o = {1'b0, WORD_W'(0) - mag[WORD_W-1:0]};
			end
		end
		return o;
	endfunction

	// Drop the extra fraction bits, rounding toward minus infinity.
	function automatic logic [WORD_W:0] shift_floor(input logic neg,
			input logic [PROD_W-1:0] mag);
		logic [PROD_W-1:0] sh;
		if (neg) begin
			sh = (mag + FRAC_MASK) >> FRAC_BITS;
		end else begin
			sh = mag >> FRAC_BITS;
		end
		return pack(neg, sh);
	endfunction

	logic en;

	// Stage 1 signals.
	vec_t ma;
	vec_t mb;
	vec_t mx;
	logic [LANES-1:0] an;
	logic [LANES-1:0] bn;
	logic [LANES-1:0] xn;
	logic [WORD_W-1:0] ms;
	logic sn;
	vec_t r1;
	logic sat1;
	logic v_s1;
	op_t op_s1;
	pvec_t pa_s1;
	pvec_t pb_s1;
	pvec_t px_s1;
	logic [LANES-1:0] xn_s1;
	vec_t r_s1;
	logic sat_s1;
	vec_t ma_s1;
	logic [LANES-1:0] an_s1;

	// Stage 2 signals.
	logic v_s2;
	op_t op_s2;
	logic [PROD_W-1:0] sqa_s2;
	logic [PROD_W-1:0] sqb_s2;
	logic [PROD_W-1:0] pos_s2;
	logic [PROD_W-1:0] neg_s2;
	pvec_t px_s2;
	logic [LANES-1:0] xn_s2;
	vec_t r_s2;
	logic sat_s2;
	vec_t ma_s2;
	logic [LANES-1:0] an_s2;

	// Stage 3 and the line that waits for the square roots.
	side_t s3n;
	side_t side_s3;
	logic v_s3;
	side_t side_d [SQ_DLY];
	logic v_d [SQ_DLY];
	logic [ROOT_W-1:0] root_a;
	logic [ROOT_W-1:0] root_b;

	// Stage 4 and the line that waits for the dividers.
	side_t s4n;
	side_t side_s4;
	logic v_s4;
	logic [PROD_W-1:0] d_s4;
	logic [ROOT_W-1:0] na_s4;
	side_t side_e [STEPS];
	logic v_e [STEPS];
	logic [STEPS-1:0] q_cos;
	logic [LANES-1:0][STEPS-1:0] q_nrm;

	// Output register.
	res_t res_n;
	res_t res_q;
	logic res_valid_q;

	// The whole pipeline moves when the output register can take a word.
	assign en = !res_valid_q || res_ready;
	assign pop = en && head_valid;

	// Stage 1: magnitudes, add and subtract, and operands for the multipliers.
	always_comb begin
		logic [WORD_W:0] sum;
		sn = head_item.sf[WORD_W-1];
		ms = sn ? (~head_item.sf + WORD_W'(1)) : head_item.sf;
		sat1 = 1'b0;
		sum = '0;
		for (int i = 0; i < LANES; i++) begin
			an[i] = head_item.a[i][WORD_W-1];
			bn[i] = head_item.b[i][WORD_W-1];
			ma[i] = an[i] ? (~head_item.a[i] + WORD_W'(1)) : head_item.a[i];
			mb[i] = bn[i] ? (~head_item.b[i] + WORD_W'(1)) : head_item.b[i];
			if (head_item.op == OP_SCALE) begin
				mx[i] = ms;
				xn[i] = an[i] ^ sn;
			end else begin
				mx[i] = mb[i];
				xn[i] = an[i] ^ bn[i];
			end
			if (head_item.op == OP_SUB) begin
				sum = {head_item.a[i][WORD_W-1], head_item.a[i]} -
					{head_item.b[i][WORD_W-1], head_item.b[i]};
			end else begin
				sum = {head_item.a[i][WORD_W-1], head_item.a[i]} +
					{head_item.b[i][WORD_W-1], head_item.b[i]};
			end
			if (head_item.op == OP_ADD || head_item.op == OP_SUB) begin
				if (sum[WORD_W] != sum[WORD_W-1]) begin
					sat1 = 1'b1;
					r1[i] = sum[WORD_W] ? NEG_MAX[WORD_W-1:0] : POS_MAX[WORD_W-1:0];
				end else begin
					r1[i] = sum[WORD_W-1:0];
				end
			end else begin
				r1[i] = '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			op_s1 <= head_item.op;
			for (int i = 0; i < LANES; i++) begin
				pa_s1[i] <= {32'd0, ma[i]} * {32'd0, ma[i]};
				pb_s1[i] <= {32'd0, mb[i]} * {32'd0, mb[i]};
				px_s1[i] <= {32'd0, ma[i]} * {32'd0, mx[i]};
			end
			xn_s1 <= xn;
			r_s1 <= r1;
			sat_s1 <= sat1;
			ma_s1 <= ma;
			an_s1 <= an;
		end
	end

	// Stage 2: sums of the products. Cross products split by sign.
	always_ff @(posedge clk) begin
		logic [PROD_W-1:0] pos;
		logic [PROD_W-1:0] neg;
		if (en) begin
			pos = '0;
			neg = '0;
			for (int i = 0; i < LANES; i++) begin
				if (xn_s1[i]) begin
					neg = neg + px_s1[i];
				end else begin
					pos = pos + px_s1[i];
				end
			end
			op_s2 <= op_s1;
			sqa_s2 <= pa_s1[0] + pa_s1[1] + pa_s1[2];
			sqb_s2 <= pb_s1[0] + pb_s1[1] + pb_s1[2];
			pos_s2 <= pos;
			neg_s2 <= neg;
			px_s2 <= px_s1;
			xn_s2 <= xn_s1;
			r_s2 <= r_s1;
			sat_s2 <= sat_s1;
			ma_s2 <= ma_s1;
			an_s2 <= an_s1;
		end
	end

	// Stage 3: dot product sign and magnitude, scaled and shifted results.
	always_comb begin
		logic [WORD_W:0] pk;
		s3n.op = op_s2;
		s3n.r = r_s2;
		s3n.sc = '0;
		s3n.sat = sat_s2;
		s3n.divz = 1'b0;
		s3n.mneg = pos_s2 < neg_s2;
		s3n.m = s3n.mneg ? (neg_s2 - pos_s2) : (pos_s2 - neg_s2);
		s3n.ma = ma_s2;
		s3n.an = an_s2;
		pk = '0;
		case (op_s2)
			OP_DOT: begin
				pk = shift_floor(s3n.mneg, s3n.m);
				s3n.sc = pk[WORD_W-1:0];
				s3n.sat = pk[WORD_W];
			end
			OP_NORMSQ: begin
				pk = shift_floor(1'b0, sqa_s2);
				s3n.sc = pk[WORD_W-1:0];
				s3n.sat = pk[WORD_W];
			end
			OP_SCALE: begin
				for (int i = 0; i < LANES; i++) begin
					pk = shift_floor(xn_s2[i], px_s2[i]);
					s3n.r[i] = pk[WORD_W-1:0];
					s3n.sat = s3n.sat | pk[WORD_W];
				end
			end
			default: begin
				s3n.sc = '0;
			end
		endcase
	end

	// The norms of A and B, one root bit per stage.
	vau_sqrt u_sqrt_a (
		.clk (clk),
		.en (en),
		.x (sqa_s2),
		.root (root_a)
	);

	vau_sqrt u_sqrt_b (
		.clk (clk),
		.en (en),
		.x (sqb_s2),
		.root (root_b)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			side_s3 <= s3n;
			side_d[0] <= side_s3;
			for (int k = 1; k < SQ_DLY; k++) begin
				side_d[k] <= side_d[k-1];
			end
		end
	end

	// Stage 4: norm result, zero-norm check, and the cosine divisor.
	always_comb begin
		logic [WORD_W:0] pk;
		s4n = side_d[SQ_DLY-1];
		pk = '0;
		case (s4n.op)
			OP_NORM: begin
				pk = pack(1'b0, {32'd0, root_a});
				s4n.sc = pk[WORD_W-1:0];
				s4n.sat = pk[WORD_W];
			end
			OP_NORMALIZE: begin
				s4n.divz = root_a == '0;
			end
			OP_COSINE, OP_RIGHT: begin
				s4n.divz = (root_a == '0) || (root_b == '0);
			end
			default: begin
				s4n.divz = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s4 <= s4n;
			d_s4 <= {32'd0, root_a} * {32'd0, root_b};
			na_s4 <= root_a;
			side_e[0] <= side_s4;
			for (int k = 1; k < STEPS; k++) begin
				side_e[k] <= side_e[k-1];
			end
		end
	end

	// Cosine: dot magnitude over the product of the norms.
	vau_div #(
		.W (PROD_W),
		.STEPS (STEPS)
	) u_div_cos (
		.clk (clk),
		.en (en),
		.rem0 ({2'b00, side_s4.m[PROD_W-1:2]}),
		.low (side_s4.m[1:0]),
		.den (d_s4),
		.quo (q_cos)
	);

	// Normalize: each magnitude of A over the norm of A.
	for (genvar i = 0; i < LANES; i++) begin : g_nrm
		vau_div #(
			.W (WORD_W),
			.STEPS (STEPS)
		) u_div_nrm (
			.clk (clk),
			.en (en),
			.rem0 ({2'b00, side_s4.ma[i][WORD_W-1:2]}),
			.low (side_s4.ma[i][1:0]),
			.den (na_s4),
			.quo (q_nrm[i])
		);
	end

	// Final assembly of the result word.
	always_comb begin
		side_t tl;
		logic [WORD_W-1:0] qz;
		tl = side_e[STEPS-1];
		res_n.r = tl.r;
		res_n.sc = tl.sc;
		res_n.right = 1'b0;
		res_n.sat = tl.sat;
		res_n.divz = tl.divz;
		qz = '0;
		case (tl.op)
			OP_NORMALIZE: begin
				if (!tl.divz) begin
					for (int i = 0; i < LANES; i++) begin
						qz = {{(WORD_W-STEPS){1'b0}}, q_nrm[i]};
						res_n.r[i] = tl.an[i] ? (WORD_W'(0) - qz) : qz;
					end
				end
			end
			OP_COSINE, OP_RIGHT: begin
				if (!tl.divz) begin
					qz = {{(WORD_W-STEPS){1'b0}}, q_cos};
					res_n.sc = tl.mneg ? (WORD_W'(0) - qz) : qz;
					res_n.right = (tl.op == OP_RIGHT) && (q_cos == '0);
				end
			end
			default: begin
				res_n.right = 1'b0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (en) begin
			res_q <= res_n;
		end
	end

	// Word-valid flags along the pipeline.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			for (int k = 0; k < SQ_DLY; k++) begin
				v_d[k] <= 1'b0;
			end
			for (int k = 0; k < STEPS; k++) begin
				v_e[k] <= 1'b0;
			end
			res_valid_q <= 1'b0;
		end else if (en) begin
			v_s1 <= head_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_d[0] <= v_s3;
			for (int k = 1; k < SQ_DLY; k++) begin
				v_d[k] <= v_d[k-1];
			end
			v_s4 <= v_d[SQ_DLY-1];
			v_e[0] <= v_s4;
			for (int k = 1; k < STEPS; k++) begin
				v_e[k] <= v_e[k-1];
			end
			res_valid_q <= v_e[STEPS-1];
		end
	end

	assign res_valid = res_valid_q;
	assign res = res_q;

endmodule

@@ rtl/vector3_arithmetic_unit.sv @@
// Three-component vector unit in signed fixed point with FRAC_BITS fraction
// bits (Q16.16 by default): add, subtract, dot product, scale, squared norm,
// norm, normalize, cosine and right-angle test, one result word per input
// word, with saturation and divide-by-zero flags. It accepts one word per
// cycle while the output is not stalled and keeps that rate for any mix of
// commands. Results pass the 32-stage square root pipeline for the norms
// and then the FRAC_BITS + 2 stage divider pipelines for normalize and
// cosine; every command travels the same path, so results leave in order.
// While the output is stalled the whole pipeline holds, and a four-word
// queue at the input takes up to four more words before the input ready
// drops.
module vector3_arithmetic_unit #(
	parameter int FRAC_BITS = 16
) (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	output logic in_ready,
	input logic [3:0] command,
	input logic signed [31:0] ax,
	input logic signed [31:0] ay,
	input logic signed [31:0] az,
	input logic signed [31:0] bx,
	input logic signed [31:0] by_comp,
	input logic signed [31:0] bz,
	input logic signed [31:0] scale_factor,
	output logic out_valid,
	input logic out_ready,
	output logic signed [31:0] rx,
	output logic signed [31:0] ry,
	output logic signed [31:0] rz,
	output logic signed [31:0] scalar_out,
	output logic right_angle,
	output logic saturated,
	output logic divide_by_zero
);
	import vau_pkg::*;

	raw_t in_word;
	item_t head_item;
	logic head_valid;
	logic pop;
	res_t res;

	// Gather the input word.
	assign in_word.cmd = command;
	assign in_word.a = {az, ay, ax};
	assign in_word.b = {bz, by_comp, bx};
	assign in_word.sf = scale_factor;

	vau_front u_front (
		.clk (clk),
		.arst_n (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_word (in_word),
		.pop (pop),
		.head_valid (head_valid),
		.head_item (head_item)
	);

	vau_back #(
		.FRAC_BITS (FRAC_BITS)
	) u_back (
		.clk (clk),
		.arst_n (arst_n),
		.head_valid (head_valid),
		.head_item (head_item),
		.pop (pop),
		.res_valid (out_valid),
		.res_ready (out_ready),
		.res (res)
	);

	// Spread the result word onto the output ports.
	assign rx = res.r[0];
	assign ry = res.r[1];
	assign rz = res.r[2];
	assign scalar_out = res.sc;
	assign right_angle = res.right;
	assign saturated = res.sat;
	assign divide_by_zero = res.divz;

endmodule

@@ rtl/vau_checker.sv @@
module vau_checker (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input logic [31:0] rx,
	input logic [31:0] ry,
	input logic [31:0] rz,
	input logic [31:0] scalar_out,
	input logic right_angle,
	input logic saturated,
	input logic divide_by_zero
);

	// A stalled result word stays offered.
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result word dropped while stalled");

	// A stalled result word keeps its value.
	a_out_stable: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(rx) && $stable(ry) && $stable(rz) &&
			$stable(scalar_out) && $stable(right_angle) && $stable(saturated) &&
			$stable(divide_by_zero))
		else $error("result word changed while stalled");

	// A zero norm clears every value field.
	a_divz_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && divide_by_zero |-> rx == 32'd0 && ry == 32'd0 && rz == 32'd0 &&
			scalar_out == 32'd0 && !right_angle && !saturated)
		else $error("divide by zero with nonzero result");

	// A right angle means a clean zero cosine and no vector result.
	a_right_zero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && right_angle |-> scalar_out == 32'd0 && !divide_by_zero &&
			!saturated && rx == 32'd0 && ry == 32'd0 && rz == 32'd0)
		else $error("right angle with nonzero cosine");

endmodule

bind vector3_arithmetic_unit vau_checker u_vau_checker (.*);

@@ tb/sv/vector3_arithmetic_unit_test.sv @@
`timescale 1ns / 1ps

module vector3_arithmetic_unit_test;
	import vau_pkg::*;

	localparam int FRAC = 16;
	localparam int RANDOM_WORDS = 850;
	localparam int CALM_WORDS = 120;
	localparam int DRAIN_CYCLES = 120;
	localparam int CYCLE_LIMIT = 400000;
	localparam logic [CMD_W-1:0] CMD_UNUSED_LO = 4'd9;
	localparam logic [CMD_W-1:0] CMD_UNUSED_HI = 4'd15;
	localparam logic [31:0] Q_ONE = 32'h0001_0000;
	localparam logic [31:0] W_MAX = 32'h7FFF_FFFF;
	localparam logic [31:0] W_MIN = 32'h8000_0000;

	// One row of the directed table: a word and, where obvious, its result.
	typedef struct {
		raw_t w;
		bit typed;
		res_t want;
	} stim_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic [3:0] command = '0;
	logic signed [31:0] ax = '0, ay = '0, az = '0;
	logic signed [31:0] bx = '0, by_comp = '0, bz = '0;
	logic signed [31:0] scale_factor = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] rx, ry, rz, scalar_out;
	logic right_angle, saturated, divide_by_zero;

	res_t pending_results[$];
	stim_row_t dir_rows[$];
	int error_count = 0;
	int results_checked = 0;
	int words_sent = 0;
	int cmd_hits[16];
	int cycles = 0;
	bit calm = 1'b0;

	vector3_arithmetic_unit #(.FRAC_BITS(FRAC)) dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.command(command), .ax(ax), .ay(ay), .az(az),
		.bx(bx), .by_comp(by_comp), .bz(bz), .scale_factor(scale_factor),
		.out_valid(out_valid), .out_ready(out_ready),
		.rx(rx), .ry(ry), .rz(rz), .scalar_out(scalar_out),
		.right_angle(right_angle), .saturated(saturated),
		.divide_by_zero(divide_by_zero)
	);

	always #5 clk = ~clk;

	// Run guard.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles", cycles);
			$display("vector3_arithmetic_unit_test: done, errors");
			$finish;
		end
	end

	// Fixed-point helpers for the predictor.
	function automatic logic [63:0] magnitude(input logic [31:0] w, output bit neg);
		neg = w[31];
		return neg ? {32'd0, -w} : {32'd0, w};
	endfunction

	function automatic logic [31:0] clip_word(input bit neg, input logic [63:0] mag,
			inout bit sat);
		if (!neg) begin
			if (mag > 64'h7FFF_FFFF) begin
				sat = 1'b1;
				mag = 64'h7FFF_FFFF;
			end
			return mag[31:0];
		end
		if (mag > 64'h8000_0000) begin
			sat = 1'b1;
			mag = 64'h8000_0000;
		end
		return 32'd0 - mag[31:0];
	endfunction

	function automatic logic [31:0] floor_shift(input bit neg, input logic [63:0] mag,
			inout bit sat);
		logic [63:0] mask;
		mask = (64'd1 << FRAC) - 1;
		if (neg)
			return clip_word(1'b1, (mag + mask) >> FRAC, sat);
		return clip_word(1'b0, mag >> FRAC, sat);
	endfunction

	function automatic logic [63:0] exact_dot(input vec_t a, input vec_t b, output bit neg);
		logic [63:0] pos, negsum, ma, mb;
		bit na, nb;
		pos = 0;
		negsum = 0;
		for (int i = 0; i < 3; i++) begin
			ma = magnitude(a[i], na);
			mb = magnitude(b[i], nb);
			if (na != nb)
				negsum += ma * mb;
			else
				pos += ma * mb;
		end
		neg = pos < negsum;
		return neg ? negsum - pos : pos - negsum;
	endfunction

	function automatic logic [63:0] floor_sqrt(input logic [63:0] x);
		logic [63:0] root, bitv;
		root = 0;
		bitv = 64'd1 << 62;
		while (bitv > x)
			bitv >>= 2;
		while (bitv != 0) begin
			if (x >= root + bitv) begin
				x -= root + bitv;
				root = (root >> 1) + bitv;
			end else begin
				root >>= 1;
			end
			bitv >>= 2;
		end
		return root;
	endfunction

	// Expected result word for one accepted input word.
	function automatic res_t vector_result(input raw_t w);
		res_t r;
		bit sat, neg, na, ns;
		logic [63:0] m, ma, ms, n, nb, d, q, rem;
		longint va, vb, s;
		r = '0;
		sat = 1'b0;
		case (w.cmd)
			CMD_ADD, CMD_SUB: begin
				for (int i = 0; i < 3; i++) begin
					va = longint'(signed'(w.a[i]));
					vb = longint'(signed'(w.b[i]));
					s = (w.cmd == CMD_ADD) ? va + vb : va - vb;
					r.r[i] = clip_word(s < 0, s < 0 ? -s : s, sat);
				end
			end
			CMD_DOT, CMD_NORMSQ: begin
				m = exact_dot(w.a, (w.cmd == CMD_DOT) ? w.b : w.a, neg);
				r.sc = floor_shift(neg, m, sat);
			end
			CMD_SCALE: begin
				ms = magnitude(w.sf, ns);
				for (int i = 0; i < 3; i++) begin
					ma = magnitude(w.a[i], na);
					r.r[i] = floor_shift(na != ns, ma * ms, sat);
				end
			end
			CMD_NORM, CMD_NORMALIZE: begin
				n = floor_sqrt(exact_dot(w.a, w.a, neg));
				if (w.cmd == CMD_NORM)
					r.sc = clip_word(1'b0, n, sat);
				else if (n == 0)
					r.divz = 1'b1;
				else
					for (int i = 0; i < 3; i++) begin
						ma = magnitude(w.a[i], na);
						r.r[i] = clip_word(na, (ma << FRAC) / n, sat);
					end
			end
			CMD_COSINE, CMD_RIGHT: begin
				n = floor_sqrt(exact_dot(w.a, w.a, neg));
				nb = floor_sqrt(exact_dot(w.b, w.b, neg));
				if (n == 0 || nb == 0) begin
					r.divz = 1'b1;
				end else begin
					d = n * nb;
					m = exact_dot(w.a, w.b, neg);
					q = m / d;
					rem = m % d;
					if (q > 64'hFFFF_FFFF)
						q = 64'hFFFF_FFFF;
					// Long division for the fraction bits, without overflowing rem.
					for (int i = 0; i < FRAC; i++) begin
						q <<= 1;
						if (rem >= d - rem) begin
							rem -= d - rem;
							q |= 1;
						end else begin
							rem <<= 1;
						end
					end
					r.sc = clip_word(neg, q, sat);
					r.right = (w.cmd == CMD_RIGHT) && (r.sc == 0);
				end
			end
			default: ;
		endcase
		r.sat = sat;
		return r;
	endfunction

	// Mismatch report: one line per failure.
	task automatic report(input string what, input logic [31:0] got, input logic [31:0] want);
		error_count++;
		$display("%0t: %s got %h want %h", $realtime, what, got, want);
	endtask

	// Output side: compare each accepted word with the oldest expectation.
	always @(posedge clk) begin
		res_t e;
		if (out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				report("unexpected result scalar_out", scalar_out, 32'd0);
			end else begin
				e = pending_results.pop_front();
				results_checked++;
				if (rx !== e.r[0]) report("rx", rx, e.r[0]);
				if (ry !== e.r[1]) report("ry", ry, e.r[1]);
				if (rz !== e.r[2]) report("rz", rz, e.r[2]);
				if (scalar_out !== e.sc) report("scalar_out", scalar_out, e.sc);
				if (right_angle !== e.right) report("right_angle", right_angle, e.right);
				if (saturated !== e.sat) report("saturated", saturated, e.sat);
				if (divide_by_zero !== e.divz)
					report("divide_by_zero", divide_by_zero, e.divz);
			end
		end
	end

	// Output stalls come in random bursts, none in the calm stretch.
	int stall_left = 0;
	always @(posedge clk) begin
		if (calm) begin
			out_ready <= 1'b1;
		end else if (stall_left > 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if ($urandom_range(0, 5) == 0) begin
			stall_left <= $urandom_range(0, 7);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	// Present one word and hold it until it is accepted.
	task automatic send_word(input raw_t w, input res_t want);
		command <= w.cmd;
		ax <= w.a[0];
		ay <= w.a[1];
		az <= w.a[2];
		bx <= w.b[0];
		by_comp <= w.b[1];
		bz <= w.b[2];
		scale_factor <= w.sf;
		in_valid <= 1'b1;
		@(posedge clk);
		while (!in_ready)
			@(posedge clk);
		pending_results.push_back(want);
		words_sent++;
		cmd_hits[w.cmd]++;
		// Random idle burst on the input side.
		if (!calm && $urandom_range(0, 4) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 8))
				@(posedge clk);
		end
	endtask

	function automatic raw_t mk(input logic [3:0] c, input logic [31:0] x0, y0, z0,
			x1, y1, z1, f);
		raw_t w;
		w.cmd = c;
		w.a = {z0, y0, x0};
		w.b = {z1, y1, x1};
		w.sf = f;
		return w;
	endfunction

	function automatic void add_row(input raw_t w, input bit typed, input res_t want);
		stim_row_t row;
		row.w = w;
		row.typed = typed;
		row.want = want;
		dir_rows.push_back(row);
	endfunction

	// Random operand with weight on extremes, zero and small values.
	function automatic logic [31:0] rnd_word();
		case ($urandom_range(0, 7))
			0: return W_MAX;
			1: return W_MIN;
			2: return 32'd0;
			3, 4: return $urandom_range(0, 32'h000C_0000) - 32'h0006_0000;
			default: return $urandom();
		endcase
	endfunction

	function automatic raw_t rnd_item();
		raw_t w;
		logic [31:0] x, y;
		w.cmd = ($urandom_range(0, 9) == 0)
			? 4'($urandom_range(CMD_UNUSED_LO, CMD_UNUSED_HI))
			: 4'($urandom_range(CMD_ADD, CMD_RIGHT));
		for (int i = 0; i < 3; i++) begin
			w.a[i] = rnd_word();
			w.b[i] = rnd_word();
		end
		w.sf = rnd_word();
		// Zero vectors for the divide cases.
		if ($urandom_range(0, 9) == 0) w.a = '0;
		if ($urandom_range(0, 11) == 0) w.b = '0;
		// Orthogonal pair so the right-angle test can pass.
		if (w.cmd == CMD_RIGHT && $urandom_range(0, 1)) begin
			x = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
			y = $urandom_range(0, 32'h0010_0000) - 32'h0008_0000;
			w.a = {32'd0, y, x};
			w.b = {rnd_word() >>> 4, x, -y};
		end
		return w;
	endfunction

	initial begin
		res_t z, t;
		raw_t w;
		int unused_hits;
		z = '0;
		for (int i = 0; i < 16; i++)
			cmd_hits[i] = 0;

		// Directed table.
		add_row(mk(CMD_ADD, 0, 0, 0, 0, 0, 0, 0), 1, z);
		t = z; t.r = {W_MAX, W_MAX, W_MAX}; t.sat = 1;
		add_row(mk(CMD_ADD, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, W_MAX, 0), 1, t);
		t = z; t.r = {W_MIN, W_MIN, W_MIN}; t.sat = 1;
		add_row(mk(CMD_SUB, W_MIN, W_MIN, W_MIN, W_MAX, W_MAX, W_MAX, 0), 1, t);
		add_row(mk(CMD_SUB, W_MAX, 1, W_MIN, W_MIN, W_MAX, 0, 0), 0, z);
		add_row(mk(CMD_DOT, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, W_MIN, 0), 0, z);
		add_row(mk(CMD_DOT, W_MAX, W_MIN, 3, W_MIN, W_MAX, -5, 0), 0, z);
		add_row(mk(CMD_SCALE, W_MAX, W_MIN, -1, 0, 0, 0, W_MIN), 0, z);
		add_row(mk(CMD_SCALE, Q_ONE, -Q_ONE, 7, 0, 0, 0, Q_ONE), 0, z);
		add_row(mk(CMD_NORMSQ, W_MIN, W_MIN, W_MIN, 0, 0, 0, 0), 0, z);
		t = z; t.sc = 32'h0005_0000;
		add_row(mk(CMD_NORM, 32'h0003_0000, 32'h0004_0000, 0, 0, 0, 0, 0), 1, t);
		add_row(mk(CMD_NORM, W_MIN, W_MIN, W_MIN, 0, 0, 0, 0), 0, z);
		t = z; t.r[0] = Q_ONE;
		add_row(mk(CMD_NORMALIZE, Q_ONE, 0, 0, 0, 0, 0, 0), 1, t);
		t = z; t.divz = 1;
		add_row(mk(CMD_NORMALIZE, 0, 0, 0, 1, 2, 3, 0), 1, t);
		add_row(mk(CMD_NORMALIZE, 1, 0, 0, 0, 0, 0, 0), 0, z);
		add_row(mk(CMD_COSINE, Q_ONE, 2, 3, 0, 0, 0, 0), 1, t);
		add_row(mk(CMD_RIGHT, 0, 0, 0, Q_ONE, 0, 0, 0), 1, t);
		add_row(mk(CMD_COSINE, 5, 7, -9, 5, 7, -9, 0), 0, z);
		add_row(mk(CMD_COSINE, W_MIN, W_MIN, W_MIN, W_MAX, W_MAX, W_MAX, 0), 0, z);
		t = z; t.right = 1;
		add_row(mk(CMD_RIGHT, Q_ONE, 0, 0, 0, Q_ONE, 0, 0), 1, t);
		// A cosine so small it truncates to zero still counts as a right angle.
		add_row(mk(CMD_RIGHT, W_MAX, 0, 0, 1, W_MAX, 0, 0), 0, z);
		add_row(mk(CMD_RIGHT, 3, 4, 0, 4, 3, 0, 0), 0, z);
		add_row(mk(CMD_UNUSED_LO, W_MAX, 1, 2, 3, 4, 5, W_MIN), 1, z);
		add_row(mk(CMD_UNUSED_HI, W_MIN, -1, -1, -1, -1, -1, -1), 1, z);

		// Reset once, inputs already known.
		repeat (8)
			@(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		foreach (dir_rows[i])
			send_word(dir_rows[i].w,
				dir_rows[i].typed ? dir_rows[i].want : vector_result(dir_rows[i].w));

		for (int i = 0; i < RANDOM_WORDS; i++) begin
			// Halfway through, let the unit drain completely once.
			if (i == RANDOM_WORDS / 2) begin
				in_valid <= 1'b0;
				while (pending_results.size() != 0)
					@(posedge clk);
			end
			if (i == RANDOM_WORDS - CALM_WORDS)
				calm = 1'b1;
			w = rnd_item();
			send_word(w, vector_result(w));
		end
		in_valid <= 1'b0;

		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES)
			@(posedge clk);

		unused_hits = 0;
		for (int c = int'(CMD_UNUSED_LO); c <= int'(CMD_UNUSED_HI); c++)
			unused_hits += cmd_hits[c];
		$display("sent %0d words (%0d right-angle, %0d unused codes), checked %0d results",
			words_sent, cmd_hits[CMD_RIGHT], unused_hits, results_checked);
		$display("mismatches: %0d", error_count);
		if (error_count == 0 && pending_results.size() == 0)
			$display("vector3_arithmetic_unit_test: done, clean");
		else
			$display("vector3_arithmetic_unit_test: done, errors");
		$finish;
	end

endmodule
